/* design/sparse_polynomial_arith_defines.svh */
// Assertion macros for the sparse polynomial block.
// No dependencies; included by the top level.
`ifndef SPARSE_POLYNOMIAL_ARITH_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ARITH_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPA_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

/* design/spa_pkg.sv */
// Types and constants for the sparse polynomial block.
// No dependencies.
package spa_pkg;
    localparam int MAX_TERMS = 8;
    localparam int PROD_DEPTH = 64;
    localparam int TW = $clog2(MAX_TERMS + 1);
    localparam int TIW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int PW = $clog2(PROD_DEPTH);

    localparam logic [2:0] CMD_LOAD_A = 3'd0;
    localparam logic [2:0] CMD_LOAD_B = 3'd1;
    localparam logic [2:0] CMD_ADD    = 3'd2;
    localparam logic [2:0] CMD_SUB    = 3'd3;
    localparam logic [2:0] CMD_MUL    = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] coefficient;
        logic [7:0]         exponent;
    } t_in;

    typedef struct packed {
        logic signed [39:0] result_coefficient;
        logic [8:0]         result_exponent;
        logic               present;
        logic               last;
    } t_out;
endpackage

/* design/sparse_polynomial_arith.sv */
// Sparse polynomial add, subtract and multiply over term memories.
// One command in flight. Loads and clear complete in the idle state. Add/subtract: per
// result word a term memory read, a decide and an emit. Multiply: per product term a read,
// a multiply, a read and check per entry scanned or a read and write per entry shifted, an
// insert and an advance; then a read and an emit per emitted word. Output stalls hold emits.
// Reset (synchronous, active low) clears counts and control; memories hold garbage.
`include "sparse_polynomial_arith_defines.svh"
module sparse_polynomial_arith (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  spa_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output spa_pkg::t_out o_data
);
    import spa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MRD, S_MDO, S_XRD, S_XMUL, S_PRD, S_PCHK, S_SHRD, S_SHWR,
        S_PUT, S_ERD, S_EDO, S_EMIT
    } t_state;

    // term memories: A and B
    logic signed [15:0] a_coef_mem [MAX_TERMS];
    logic [7:0]         a_exp_mem  [MAX_TERMS];
    logic signed [15:0] b_coef_mem [MAX_TERMS];
    logic [7:0]         b_exp_mem  [MAX_TERMS];
    // product memory, one write and one read port
    logic signed [39:0] p_coef_mem [PROD_DEPTH];
    logic [8:0]         p_exp_mem  [PROD_DEPTH];

    t_state r_state;
    logic [TW-1:0] r_a_cnt, r_b_cnt, r_i, r_j;
    logic [PW:0]   r_p_cnt, r_p, r_q;
    logic          r_sub, r_any;
    logic signed [15:0] r_ca, r_cb;
    logic [7:0]    r_ea, r_eb;
    logic signed [39:0] r_pc, r_rc;
    logic [8:0]    r_pe, r_re;
    logic signed [39:0] r_ms;   // product memory read data
    logic [8:0]    r_me;
    logic          r_ov;
    t_out          r_out;
    t_out          r_pend;       // word waiting to be emitted
    logic          r_pend_last_known;

    // memory ports
    logic          p_we;
    logic [PW-1:0] p_wa, p_ra;
    logic signed [39:0] p_wc;
    logic [8:0]    p_wex;

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            p_coef_mem[p_wa] <= p_wc;
            p_exp_mem[p_wa]  <= p_wex;
        end
        r_ms <= p_coef_mem[p_ra];
        r_me <= p_exp_mem[p_ra];
    end

    assign o_stall = (r_state != S_IDLE) || (r_ov && i_stall);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    logic in_acc;
    assign in_acc = i_valid && !o_stall;
    logic out_free;
    assign out_free = !r_ov || !i_stall;
    // a word enters the output register this cycle
    logic out_load;
    assign out_load = ((r_state == S_EMIT) || (r_state == S_EDO)) && out_free;

    // merge step decisions
    logic i_more, j_more;
    assign i_more = r_i < r_a_cnt;
    assign j_more = r_j < r_b_cnt;

    always_comb begin
        p_we  = 1'b0;
        p_wa  = r_p[PW-1:0];
        p_wc  = r_pc;
        p_wex = r_pe;
        p_ra  = r_p[PW-1:0];
        case (r_state)
            S_PCHK: begin
                if (r_p < r_p_cnt && r_me == r_pe) begin
                    p_we = 1'b1;
                    p_wc = r_ms + r_pc;
                end
            end
            S_SHRD:  p_ra = r_q[PW-1:0] - 1'b1;
            S_SHWR: begin
                p_we = 1'b1;
                p_wa = r_q[PW-1:0];
                p_wc = r_ms;
                p_wex = r_me;
            end
            S_PUT:   p_we = 1'b1;
            S_PRD:   p_ra = r_p[PW-1:0];
            S_ERD:   p_ra = r_p[PW-1:0];
            default: ;
        endcase
    end

    // main control: loads, merge, multiply and emit; the emit states wait while the output port is busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a_cnt <= '0;
            r_b_cnt <= '0;
            r_p_cnt <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (out_load) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_data.cmd)
                            CMD_LOAD_A: if (r_a_cnt < TW'(MAX_TERMS)) begin
                                a_coef_mem[r_a_cnt[TIW-1:0]] <= i_data.coefficient;
                                a_exp_mem[r_a_cnt[TIW-1:0]]  <= i_data.exponent;
                                r_a_cnt <= r_a_cnt + 1'b1;
                            end
                            CMD_LOAD_B: if (r_b_cnt < TW'(MAX_TERMS)) begin
                                b_coef_mem[r_b_cnt[TIW-1:0]] <= i_data.coefficient;
                                b_exp_mem[r_b_cnt[TIW-1:0]]  <= i_data.exponent;
                                r_b_cnt <= r_b_cnt + 1'b1;
                            end
                            CMD_ADD, CMD_SUB: begin
                                r_sub <= (i_data.cmd == CMD_SUB);
                                r_i <= '0; r_j <= '0; r_any <= 1'b0;
                                r_state <= S_MRD;
                            end
                            CMD_MUL: begin
                                r_p_cnt <= '0;
                                r_i <= '0; r_j <= '0; r_any <= 1'b0;
                                r_state <= (r_a_cnt != 0 && r_b_cnt != 0) ? S_XRD : S_ERD;
                                r_p <= '0;
                            end
                            CMD_CLEAR: begin
                                r_a_cnt <= '0; r_b_cnt <= '0; r_p_cnt <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MRD: begin
                    r_ca <= a_coef_mem[r_i[TIW-1:0]];
                    r_ea <= a_exp_mem[r_i[TIW-1:0]];
                    r_cb <= b_coef_mem[r_j[TIW-1:0]];
                    r_eb <= b_exp_mem[r_j[TIW-1:0]];
                    r_state <= S_MDO;
                end
                S_MDO: begin
                    // decide one merged term
                    if (!i_more && !j_more) begin
                        r_pend <= '{40'sd0, 9'd0, 1'b0, 1'b1};
                        r_pend_last_known <= 1'b1;
                        r_state <= r_any ? S_IDLE : S_EMIT;
                    end else begin
                        if (i_more && j_more && r_ea == r_eb) begin
                            r_rc <= r_sub ? 40'(r_ca) - 40'(r_cb) : 40'(r_ca) + 40'(r_cb);
                            r_re <= {1'b0, r_ea};
                            r_i <= r_i + 1'b1; r_j <= r_j + 1'b1;
                        end else if (i_more && (!j_more ? 1'b0 : r_ea > r_eb)) begin
                            r_rc <= 40'(r_ca); r_re <= {1'b0, r_ea};
                            r_i <= r_i + 1'b1;
                        end else if (j_more) begin
                            r_rc <= r_sub ? -40'(r_cb) : 40'(r_cb);
                            r_re <= {1'b0, r_eb};
                            r_j <= r_j + 1'b1;
                        end else begin
                            r_rc <= 40'(r_ca); r_re <= {1'b0, r_ea};
                            r_i <= r_i + 1'b1;
                        end
                        r_pend_last_known <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_any <= 1'b1;
                        if (r_pend_last_known) begin
                            r_out <= r_pend;
                            r_state <= S_IDLE;
                        end else begin
                            r_out.result_coefficient <= r_rc;
                            r_out.result_exponent <= r_re;
                            r_out.present <= 1'b1;
                            // last when both stores are exhausted after this term
                            r_out.last <= !i_more && !j_more;
                            r_state <= (!i_more && !j_more) ? S_IDLE :
                                       (r_pend_last_known ? S_IDLE : S_MRD);
                        end
                    end
                end
                S_XRD: begin
                    r_ca <= a_coef_mem[r_i[TIW-1:0]];
                    r_ea <= a_exp_mem[r_i[TIW-1:0]];
                    r_cb <= b_coef_mem[r_j[TIW-1:0]];
                    r_eb <= b_exp_mem[r_j[TIW-1:0]];
                    r_state <= S_XMUL;
                end
                S_XMUL: begin
                    r_pc <= 40'(32'(r_ca) * 32'(r_cb));
                    r_pe <= 9'(r_ea) + 9'(r_eb);
                    r_p <= '0;
                    r_state <= S_PRD;
                end
                S_PRD: r_state <= S_PCHK;   // read entry r_p
                S_PCHK: begin
                    if (r_p < r_p_cnt && r_me == r_pe) begin
                        r_state <= S_SHRD;  // added in place; reuse path to advance
                        r_q <= r_p;
                    end else if (r_p < r_p_cnt && r_me >= r_pe) begin
                        r_p <= r_p + 1'b1;
                        r_state <= S_PRD;
                    end else if (r_p_cnt >= (PW+1)'(PROD_DEPTH)) begin
                        r_q <= r_p;
                        r_state <= S_SHRD;
                    end else begin
                        r_q <= r_p_cnt;
                        r_state <= (r_p_cnt == r_p) ? S_PUT : S_SHRD;
                    end
                end
                S_SHRD: begin
                    // q == p means nothing left to shift (or nothing to insert)
                    if (r_q == r_p) begin
                        r_state <= S_XRD;
                        if (r_j + 1'b1 < r_b_cnt) r_j <= r_j + 1'b1;
                        else begin
                            r_j <= '0;
                            if (r_i + 1'b1 < r_a_cnt) r_i <= r_i + 1'b1;
                            else begin r_p <= '0; r_state <= S_ERD; end
                        end
                    end else r_state <= S_SHWR;
                end
                S_SHWR: begin
                    r_q <= r_q - 1'b1;
                    r_state <= (r_q - 1'b1 == r_p) ? S_PUT : S_SHRD;
                end
                S_PUT: begin
                    r_p_cnt <= r_p_cnt + 1'b1;
                    r_q <= r_p;
                    r_state <= S_SHRD;
                end
                S_ERD: r_state <= S_EDO;
                S_EDO: begin
                    if (out_free) begin
                        if (r_p_cnt == 0) begin
                            r_out <= '{40'sd0, 9'd0, 1'b0, 1'b1};
                            r_state <= S_IDLE;
                        end else begin
                            r_out <= '{r_ms, r_me, 1'b1, (r_p + 1'b1 == r_p_cnt)};
                            r_p <= r_p + 1'b1;
                            r_state <= (r_p + 1'b1 == r_p_cnt) ? S_IDLE : S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SPA_ASSERT(a_cnt_max, i_clk, i_rst_n, r_a_cnt <= TW'(MAX_TERMS), "A count overflow")
    `SPA_ASSERT(p_cnt_max, i_clk, i_rst_n, r_p_cnt <= (PW+1)'(PROD_DEPTH), "product overflow")
    `SPA_ASSERT(busy_stall, i_clk, i_rst_n, (r_state != S_IDLE) |-> o_stall, "busy not stalled")
    `SPA_ASSERT_RST(rst_idle, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

/* bench/spa_checker.sv */
// Checker for the sparse polynomial block: watches both channels, predicts result words.
// Depends on spa_pkg.
module spa_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall_in,
    input  spa_pkg::t_in  i_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  spa_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_words
);
    timeunit 1ns;
    timeprecision 1ps;
    import spa_pkg::*;

    logic signed [15:0] a_coef [MAX_TERMS];
    logic [7:0]         a_exp  [MAX_TERMS];
    int                 a_num;
    logic signed [15:0] b_coef [MAX_TERMS];
    logic [7:0]         b_exp  [MAX_TERMS];
    int                 b_num;
    logic signed [39:0] prod_coef [PROD_DEPTH];
    logic [8:0]         prod_exp  [PROD_DEPTH];
    int                 prod_num;
    t_out               expected_terms [$];

    function automatic void push_term(logic signed [39:0] c, logic [8:0] e);
        t_out w;
        w.result_coefficient = c;
        w.result_exponent = e;
        w.present = 1'b1;
        w.last = 1'b0;
        expected_terms.push_back(w);
    endfunction

    // Mark the last term, or queue the empty-result word.
    function automatic void close_result(int produced);
        t_out w;
        if (produced == 0) begin
            w = '0;
            w.last = 1'b1;
            expected_terms.push_back(w);
        end else begin
            w = expected_terms.pop_back();
            w.last = 1'b1;
            expected_terms.push_back(w);
        end
    endfunction

    function automatic void predict_merge(bit negate_b);
        int i, j, n;
        logic signed [39:0] ca, cb;
        i = 0; j = 0; n = 0;
        while (i < a_num && j < b_num) begin
            ca = 40'(a_coef[i]);
            cb = 40'(b_coef[j]);
            if (a_exp[i] == b_exp[j]) begin
                push_term(negate_b ? ca - cb : ca + cb, {1'b0, a_exp[i]});
                i++; j++;
            end else if (a_exp[i] > b_exp[j]) begin
                push_term(ca, {1'b0, a_exp[i]});
                i++;
            end else begin
                push_term(negate_b ? -cb : cb, {1'b0, b_exp[j]});
                j++;
            end
            n++;
        end
        for (; j < b_num; j++) begin
            cb = 40'(b_coef[j]);
            push_term(negate_b ? -cb : cb, {1'b0, b_exp[j]});
            n++;
        end
        for (; i < a_num; i++) begin
            ca = 40'(a_coef[i]);
            push_term(ca, {1'b0, a_exp[i]});
            n++;
        end
        close_result(n);
    endfunction

    function automatic void insert_product(logic signed [39:0] c, logic [8:0] e);
        int p;
        p = 0;
        while (p < prod_num) begin
            if (prod_exp[p] == e) begin
                prod_coef[p] = prod_coef[p] + c;
                return;
            end
            if (prod_exp[p] < e) break;
            p++;
        end
        if (prod_num >= PROD_DEPTH) return;
        for (int q = prod_num; q > p; q--) begin
            prod_coef[q] = prod_coef[q-1];
            prod_exp[q] = prod_exp[q-1];
        end
        prod_coef[p] = c;
        prod_exp[p] = e;
        prod_num++;
    endfunction

    function automatic void predict_product();
        logic signed [39:0] c;
        prod_num = 0;
        for (int i = 0; i < a_num; i++)
            for (int j = 0; j < b_num; j++) begin
                c = 40'(a_coef[i]) * 40'(b_coef[j]);
                insert_product(c, {1'b0, a_exp[i]} + {1'b0, b_exp[j]});
            end
        for (int p = 0; p < prod_num; p++) push_term(prod_coef[p], prod_exp[p]);
        close_result(prod_num);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t checker: %s got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    assign o_pending = expected_terms.size();

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            a_num = 0; b_num = 0; prod_num = 0;
            o_errors = 0;
            o_words = 0;
            expected_terms.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_words++;
                if (expected_terms.size() == 0) begin
                    report_mismatch("unexpected word", 64'(i_out_data), 64'd0);
                end else begin
                    want = expected_terms.pop_front();
                    if (i_out_data.result_coefficient !== want.result_coefficient)
                        report_mismatch("coefficient", 64'(i_out_data.result_coefficient),
                                        64'(want.result_coefficient));
                    if (i_out_data.result_exponent !== want.result_exponent)
                        report_mismatch("exponent", 64'(i_out_data.result_exponent),
                                        64'(want.result_exponent));
                    if (i_out_data.present !== want.present)
                        report_mismatch("present", 64'(i_out_data.present), 64'(want.present));
                    if (i_out_data.last !== want.last)
                        report_mismatch("last", 64'(i_out_data.last), 64'(want.last));
                end
            end
            if (i_valid && !i_stall_in) begin
                case (i_data.cmd)
                    CMD_LOAD_A: if (a_num < MAX_TERMS) begin
                        a_coef[a_num] = i_data.coefficient;
                        a_exp[a_num] = i_data.exponent;
                        a_num++;
                    end
                    CMD_LOAD_B: if (b_num < MAX_TERMS) begin
                        b_coef[b_num] = i_data.coefficient;
                        b_exp[b_num] = i_data.exponent;
                        b_num++;
                    end
                    CMD_ADD:   predict_merge(1'b0);
                    CMD_SUB:   predict_merge(1'b1);
                    CMD_MUL:   predict_product();
                    CMD_CLEAR: begin
                        a_num = 0; b_num = 0; prod_num = 0;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

/* bench/tb_sparse_polynomial_arith.sv */
// Testbench top for sparse_polynomial_arith: drives command words, stalls the output,
// and gives the verdict. Depends on spa_pkg, the block, and spa_checker.
module tb_sparse_polynomial_arith;
    timeunit 1ns;
    timeprecision 1ps;
    import spa_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic  i_clk;
    logic  i_rst_n;
    logic  in_valid;
    logic  in_stall;
    t_in   in_word;
    logic  out_valid;
    logic  out_stall;
    t_out  out_word;
    int    errors, pending, words_seen;
    int    idle_cycles;
    int    words_sent;
    bit    calm;      // no output stalls in the final stretch
    bit    timed_out;

    sparse_polynomial_arith uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_word),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_word)
    );

    spa_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_stall_in  (in_stall),
        .i_data      (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_word),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_words     (words_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the output in random bursts; hold it open once calm is set.
    initial begin
        int n;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 14);
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one word and hold it until accepted; while not calm, sometimes drop valid for a random gap.
    task automatic send_word(logic [2:0] cmd, logic [15:0] coef, logic [7:0] expo);
        int gap;
        in_word <= '{cmd: cmd, coefficient: coef, exponent: expo};
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        words_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Load a polynomial of n terms with non-increasing exponents and random coefficients.
    task automatic load_sorted(logic [2:0] cmd, int n);
        int e;
        e = $urandom_range(200, 255);
        for (int k = 0; k < n; k++) begin
            send_word(cmd, 16'($urandom), 8'(e));
            e = e - $urandom_range(0, 2) * ($urandom_range(1, 30));
            if (e < 0) e = 0;
        end
    endtask

    initial begin
        int r, na, nb;
        logic [2:0] ops [3];
        ops = '{CMD_ADD, CMD_SUB, CMD_MUL};
        calm = 1'b0;
        words_sent = 0;
        in_valid <= 1'b0;
        in_word <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty stores: add and multiply give the empty-result word.
        send_word(CMD_ADD, 16'h0, 8'h0);
        send_word(CMD_MUL, 16'h0, 8'h0);
        // Field extremes, equal exponents that cancel, lone B terms on subtract.
        send_word(CMD_LOAD_A, 16'h7FFF, 8'hFF);
        send_word(CMD_LOAD_A, 16'h8000, 8'h80);
        send_word(CMD_LOAD_A, 16'h0001, 8'h00);
        send_word(CMD_LOAD_B, 16'h8000, 8'hFF);
        send_word(CMD_LOAD_B, 16'h8000, 8'h7F);
        send_word(CMD_LOAD_B, 16'hFFFF, 8'h00);
        send_word(CMD_ADD, 16'hFFFF, 8'hFF);
        send_word(CMD_SUB, 16'h0, 8'h0);
        send_word(CMD_MUL, 16'h0, 8'h0);
        // Unused codes do nothing.
        send_word(3'd6, 16'h1234, 8'h55);
        send_word(3'd7, 16'hEDCB, 8'hAA);
        hold_until_drained();
        send_word(CMD_CLEAR, 16'h0, 8'h0);
        // Fill A past capacity, unsorted, then subtract with B empty.
        for (int k = 0; k < MAX_TERMS + 2; k++)
            send_word(CMD_LOAD_A, 16'($urandom), 8'($urandom));
        send_word(CMD_SUB, 16'h0, 8'h0);
        send_word(CMD_MUL, 16'h0, 8'h0);

        // Random phases: mostly sorted polynomials, some noise.
        while (words_sent < 120) begin
            if (words_sent > 95) calm = 1'b1;
            send_word(CMD_CLEAR, 16'h0, 8'h0);
            na = $urandom_range(0, 3) == 0 ? MAX_TERMS : $urandom_range(0, 4);
            nb = $urandom_range(0, 3) == 0 ? MAX_TERMS : $urandom_range(0, 4);
            if ($urandom_range(0, 4) == 0) begin
                for (int k = 0; k < na + nb; k++)
                    send_word(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom));
            end else begin
                load_sorted(CMD_LOAD_A, na);
                load_sorted(CMD_LOAD_B, nb);
            end
            r = $urandom_range(1, 3);
            for (int k = 0; k < r; k++)
                send_word(ops[$urandom_range(0, 2)], 16'($urandom), 8'($urandom));
            if ($urandom_range(0, 5) == 0) hold_until_drained();
        end

        hold_until_drained();
        repeat (300) @(posedge i_clk);
        $display("tb: %0d command words sent, %0d result words checked", words_sent,
                 words_seen);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
